// ===== rtl/midi_event_encoder_held_notes_assert.svh =====
// Assertion macros used by the checker file of the MIDI event encoder.
`ifndef MIDI_EVENT_ENCODER_HELD_NOTES_ASSERT_SVH
`define MIDI_EVENT_ENCODER_HELD_NOTES_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MEE_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("mee checker: same-cycle property failed");

// The consequent must hold in the cycle after the antecedent.
`define MEE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("mee checker: next-cycle property failed");

`endif

// ===== rtl/mee_pkg.sv =====
`timescale 1ns / 1ps

package mee_pkg;

  localparam int HELD_DEPTH = 64;
  localparam int IDX_W      = (HELD_DEPTH > 1) ? $clog2(HELD_DEPTH) : 1;
  localparam int CNT_W      = $clog2(HELD_DEPTH + 1);
  localparam int ENTRY_W    = 11;
  localparam int S_TDATA_W  = 40;
  localparam int M_TDATA_W  = 48;

  // One held note: channel in the upper four bits, key in the lower seven.
  typedef logic [ENTRY_W-1:0] entry_t;

  // Control broadcast to every cell of the held-note row.
  typedef struct packed {
    logic             shift;
    logic             wr_en;
    logic [IDX_W-1:0] wr_pos;
    entry_t           wr_data;
  } cell_ctl_t;

  typedef enum logic [3:0] {
    REQ_NOTE_ON        = 4'd0,
    REQ_NOTE_OFF       = 4'd1,
    REQ_CC             = 4'd2,
    REQ_PROGRAM        = 4'd3,
    REQ_CHAN_PRESS     = 4'd4,
    REQ_POLY_PRESS     = 4'd5,
    REQ_BEND           = 4'd6,
    REQ_IGNORE         = 4'd7,
    REQ_CHASE_CC       = 4'd8,
    REQ_CHASE_PROGRAM  = 4'd9,
    REQ_CHASE_BEND     = 4'd10,
    REQ_CHASE_PRESS    = 4'd11,
    REQ_CHASE_NOTE     = 4'd12,
    REQ_RELEASE        = 4'd13,
    REQ_PANIC          = 4'd14
  } req_t;

  // Status nibbles of the channel messages.
  localparam logic [3:0] ST_NOTE_OFF   = 4'h8;
  localparam logic [3:0] ST_NOTE_ON    = 4'h9;
  localparam logic [3:0] ST_POLY_PRESS = 4'hA;
  localparam logic [3:0] ST_CC         = 4'hB;
  localparam logic [3:0] ST_PROGRAM    = 4'hC;
  localparam logic [3:0] ST_CHAN_PRESS = 4'hD;
  localparam logic [3:0] ST_BEND       = 4'hE;

  localparam logic [1:0] LEN_NONE  = 2'd0;
  localparam logic [1:0] LEN_TWO   = 2'd2;
  localparam logic [1:0] LEN_THREE = 2'd3;

  localparam logic [6:0]  VEL_OFF_DEFAULT   = 7'd64;
  localparam logic [6:0]  VEL_CHASE_DEFAULT = 7'd100;
  localparam logic [6:0]  DATA_MAX          = 7'd127;
  localparam logic [15:0] BEND_CENTER       = 16'd8192;
  localparam logic [13:0] BEND_MAX          = 14'd16383;
  localparam logic [15:0] MASK_ALL          = 16'hFFFF;

  localparam logic CFG_FORCED_CHANNEL = 1'b0;
  localparam logic CFG_CHASE_NOTE_ONS = 1'b1;

endpackage

// ===== rtl/mee_cell.sv =====
`timescale 1ns / 1ps

module mee_cell (
  input  logic                    clk,
  input  mee_pkg::cell_ctl_t      ctl,
  input  logic [mee_pkg::IDX_W-1:0] cell_idx,
  input  mee_pkg::entry_t         nbr,
  output mee_pkg::entry_t         data
);
  import mee_pkg::*;

  logic sel;

  // A write aimed at this cell wins over the neighbor's value during a shift.
  assign sel = ctl.wr_en && (ctl.wr_pos == cell_idx);

  always_ff @(posedge clk) begin
    if (sel) begin
      data <= ctl.wr_data;
    end else if (ctl.shift) begin
      data <= nbr;
    end
  end

endmodule

// ===== rtl/midi_event_encoder_held_notes.sv =====
`timescale 1ns / 1ps

// MIDI channel message encoder with a held-note list. Each input transaction
// carries one event and yields one or more output transactions, the final one
// marked by m_tlast. After a single-message event the next event is taken in
// the cycle after, as long as the output register is free or being drained.
// A note-off with notes held keeps the input closed while the held list is
// rotated once through the row of cells to erase the first matching entry
// while keeping the order of the others. A release sends one note-off per
// cycle while the output is free or being drained, one for every held note,
// oldest first, from the release state. Panic clears the list and reports
// the used-channel mask (all channels if none was used). The held list is a
// row of HELD_DEPTH cells that shift toward cell 0; entries at and above
// held_count are never read, so the row has no reset. Configuration writes are
// always taken and must only be issued while the block is idle.
module midi_event_encoder_held_notes (
  input  logic                            clk,
  input  logic                            rst,
  // Event input. s_tdata, from bit 0: event_channel[4:0], note_key[6:0],
  // controller_number[6:0], event_value[14:0], zero padding.
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [mee_pkg::S_TDATA_W-1:0]   s_tdata,
  // s_tuser: req_type[3:0].
  input  logic [3:0]                      s_tuser,
  // Message output. m_tdata, from bit 0: status_byte[7:0], data_one[6:0],
  // data_two[6:0], message_length[1:0], channels_used[15:0],
  // held_overflow, zero padding. m_tlast is last_result.
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [mee_pkg::M_TDATA_W-1:0]   m_tdata,
  output logic                            m_tlast,
  // Configuration writes: index 0 forced_channel, index 1 chase_note_ons.
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic                            cfg_index,
  input  logic [4:0]                      cfg_data
);
  import mee_pkg::*;

  typedef struct packed {
    logic [7:0]  status;
    logic [6:0]  d1;
    logic [6:0]  d2;
    logic [1:0]  len;
    logic [15:0] used;
    logic        ovf;
    logic        last;
  } result_t;

  typedef enum logic [2:0] {
    S_IDLE    = 3'b001,
    S_ERASE   = 3'b010,
    S_RELEASE = 3'b100
  } state_t;

  state_t state, state_next;

  logic [CNT_W-1:0] held_count, held_count_next;
  logic [CNT_W-1:0] count_dec;
  logic [CNT_W-1:0] steps, steps_next;
  logic             found, found_next;
  entry_t           target, target_next;
  logic [15:0]      used_mask, used_mask_next;
  logic [4:0]       forced_channel;
  logic             chase_note_ons;

  result_t          res_q, res;
  logic             load_out;
  logic             slot_free;
  logic             in_fire;

  cell_ctl_t        cell_ctl;
  entry_t           cell_data [HELD_DEPTH];
  entry_t           nbr_data  [HELD_DEPTH];

  // Field extraction.
  req_t        req;
  logic [4:0]  ev_ch;
  logic [6:0]  key;
  logic [6:0]  ctl_num;
  logic [14:0] val;

  assign req     = req_t'(s_tuser);
  assign ev_ch   = s_tdata[4:0];
  assign key     = s_tdata[11:5];
  assign ctl_num = s_tdata[18:12];
  assign val     = s_tdata[33:19];

  // Encoding of the incoming event.
  logic [3:0]  ch;
  logic [6:0]  cv;
  logic        val_pos;
  logic [15:0] bend_sum;
  logic [13:0] bend;
  logic        full;
  result_t     enc;
  logic        enc_hold;
  logic        enc_mark;
  logic [15:0] mask_marked;

  always_comb begin
    if (!forced_channel[4]) begin
      ch = forced_channel[3:0];
    end else if (!ev_ch[4]) begin
      ch = ev_ch[3:0];
    end else begin
      ch = 4'd0;
    end

    if (val[14]) begin
      cv = 7'd0;
    end else if (|val[13:7]) begin
      cv = DATA_MAX;
    end else begin
      cv = val[6:0];
    end
    val_pos = !val[14] && (val != 15'd0);

    bend_sum = {val[14], val} + BEND_CENTER;
    if (bend_sum[15]) begin
      bend = 14'd0;
    end else if (bend_sum[14]) begin
      bend = BEND_MAX;
    end else begin
      bend = bend_sum[13:0];
    end
  end

  assign full = (held_count == CNT_W'(HELD_DEPTH));

  always_comb begin
    enc      = '0;
    enc.last = 1'b1;
    enc_hold = 1'b0;
    enc_mark = 1'b0;
    unique case (req) inside
      REQ_NOTE_ON: begin
        enc.len = LEN_THREE;
        enc.d1  = key;
        if (cv == 7'd0) begin
          // A note-on with zero velocity goes out as a plain note-off.
          enc.status = {ST_NOTE_OFF, ch};
          enc.d2     = VEL_OFF_DEFAULT;
        end else begin
          enc.status = {ST_NOTE_ON, ch};
          enc.d2     = cv;
          enc.ovf    = full;
          enc_hold   = 1'b1;
          enc_mark   = 1'b1;
        end
      end
      REQ_NOTE_OFF: begin
        enc.status = {ST_NOTE_OFF, ch};
        enc.d1     = key;
        enc.d2     = val_pos ? cv : VEL_OFF_DEFAULT;
        enc.len    = LEN_THREE;
      end
      REQ_CC, REQ_CHASE_CC: begin
        enc.status = {ST_CC, ch};
        enc.d1     = ctl_num;
        enc.d2     = cv;
        enc.len    = LEN_THREE;
        enc_mark   = 1'b1;
      end
      REQ_PROGRAM, REQ_CHASE_PROGRAM: begin
        enc.status = {ST_PROGRAM, ch};
        enc.d1     = cv;
        enc.len    = LEN_TWO;
        enc_mark   = (req == REQ_CHASE_PROGRAM);
      end
      REQ_CHAN_PRESS, REQ_CHASE_PRESS: begin
        enc.status = {ST_CHAN_PRESS, ch};
        enc.d1     = cv;
        enc.len    = LEN_TWO;
        enc_mark   = (req == REQ_CHASE_PRESS);
      end
      REQ_POLY_PRESS: begin
        enc.status = {ST_POLY_PRESS, ch};
        enc.d1     = key;
        enc.d2     = cv;
        enc.len    = LEN_THREE;
      end
      REQ_BEND, REQ_CHASE_BEND: begin
        enc.status = {ST_BEND, ch};
        enc.d1     = bend[6:0];
        enc.d2     = bend[13:7];
        enc.len    = LEN_THREE;
        enc_mark   = (req == REQ_CHASE_BEND);
      end
      REQ_CHASE_NOTE: begin
        if (chase_note_ons) begin
          enc.status = {ST_NOTE_ON, ch};
          enc.d1     = key;
          enc.d2     = val_pos ? cv : VEL_CHASE_DEFAULT;
          enc.len    = LEN_THREE;
          enc.ovf    = full;
          enc_hold   = 1'b1;
          enc_mark   = 1'b1;
        end
      end
      default: begin
        // Ignored, unknown, release with nothing held and panic carry no message.
      end
    endcase

    mask_marked = used_mask | (enc_mark ? (16'd1 << ch) : 16'd0);
    if (req == REQ_PANIC) begin
      enc.used = (used_mask == 16'd0) ? MASK_ALL : used_mask;
    end else begin
      enc.used = mask_marked;
    end
  end

  // Handshake.
  assign slot_free = !m_tvalid || m_tready;
  assign s_tready  = (state == S_IDLE) && slot_free;
  assign in_fire   = s_tvalid && s_tready;
  assign cfg_ready = 1'b1;
  assign count_dec = held_count - CNT_W'(1);

  // Sequencer for the held-note row.
  logic head_match;
  assign head_match = !found && (cell_data[0] == target);

  always_comb begin
    state_next      = state;
    held_count_next = held_count;
    steps_next      = steps;
    found_next      = found;
    target_next     = target;
    used_mask_next  = used_mask;
    cell_ctl        = '0;
    load_out        = 1'b0;
    res             = enc;

    unique case (state)
      S_IDLE: begin
        if (in_fire) begin
          used_mask_next = mask_marked;
          load_out       = 1'b1;
          if (enc_hold && !full) begin
            cell_ctl.wr_en   = 1'b1;
            cell_ctl.wr_pos  = held_count[IDX_W-1:0];
            cell_ctl.wr_data = {ch, key};
            held_count_next  = held_count + CNT_W'(1);
          end
          if (req == REQ_NOTE_OFF && held_count != '0) begin
            state_next  = S_ERASE;
            steps_next  = held_count;
            found_next  = 1'b0;
            target_next = {ch, key};
          end
          if (req == REQ_RELEASE && held_count != '0) begin
            // The note-offs come out of the release state, one per cycle while the output is free or being drained.
            state_next = S_RELEASE;
            load_out   = 1'b0;
          end
          if (req == REQ_PANIC) begin
            held_count_next = '0;
          end
        end
      end
      S_ERASE: begin
        // Pop the head and push it back at the tail, except for the first
        // entry that matches the note being released.
        cell_ctl.shift   = 1'b1;
        cell_ctl.wr_en   = !head_match;
        cell_ctl.wr_pos  = count_dec[IDX_W-1:0];
        cell_ctl.wr_data = cell_data[0];
        if (head_match) begin
          held_count_next = count_dec;
          found_next      = 1'b1;
        end
        steps_next = steps - CNT_W'(1);
        if (steps == CNT_W'(1)) begin
          state_next = S_IDLE;
        end
      end
      S_RELEASE: begin
        res.status = {ST_NOTE_OFF, cell_data[0][ENTRY_W-1:7]};
        res.d1     = cell_data[0][6:0];
        res.d2     = VEL_OFF_DEFAULT;
        res.len    = LEN_THREE;
        res.used   = used_mask;
        res.ovf    = 1'b0;
        res.last   = (held_count == CNT_W'(1));
        if (slot_free) begin
          load_out        = 1'b1;
          cell_ctl.shift  = 1'b1;
          held_count_next = count_dec;
          if (held_count == CNT_W'(1)) begin
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Row of held-note cells; each takes its upper neighbor's entry on a shift.
  for (genvar i = 0; i < HELD_DEPTH; i++) begin : g_cell
    if (i == HELD_DEPTH - 1) begin : g_tail
      assign nbr_data[i] = cell_data[i];
    end else begin : g_body
      assign nbr_data[i] = cell_data[i+1];
    end
    mee_cell u_cell (
      .clk      (clk),
      .ctl      (cell_ctl),
      .cell_idx (IDX_W'(i)),
      .nbr      (nbr_data[i]),
      .data     (cell_data[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      held_count     <= '0;
      steps          <= '0;
      found          <= 1'b0;
      used_mask      <= '0;
      forced_channel <= 5'h1F;
      chase_note_ons <= 1'b0;
      m_tvalid       <= 1'b0;
    end else begin
      state      <= state_next;
      held_count <= held_count_next;
      steps      <= steps_next;
      found      <= found_next;
      used_mask  <= used_mask_next;
      if (load_out) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_FORCED_CHANNEL: forced_channel <= cfg_data;
          CFG_CHASE_NOTE_ONS: chase_note_ons <= cfg_data[0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    target <= target_next;
    if (load_out) begin
      res_q <= res;
    end
  end

  assign m_tdata = {7'd0, res_q.ovf, res_q.used, res_q.len, res_q.d2, res_q.d1,
                    res_q.status};
  assign m_tlast = res_q.last;

endmodule

// ===== rtl/mee_checker.sv =====
`timescale 1ns / 1ps

`include "midi_event_encoder_held_notes_assert.svh"

module mee_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          m_tvalid,
  input logic                          m_tready,
  input logic [mee_pkg::M_TDATA_W-1:0] m_tdata,
  input logic                          m_tlast
);
  import mee_pkg::*;

  // A stalled result keeps its contents.
  `MEE_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast))

  // Message length is none, two or three bytes.
  `MEE_ASSERT_NOW(a_len_code, m_tvalid, m_tdata[23:22] != 2'd1)

  // An empty result has all message bytes at zero and closes its event.
  `MEE_ASSERT_NOW(a_empty_last, m_tvalid && m_tdata[23:22] == LEN_NONE, m_tdata[21:0] == 22'd0 && m_tlast)

  // Overflow is only flagged on a note-on.
  `MEE_ASSERT_NOW(a_ovf_note_on, m_tvalid && m_tdata[40], m_tdata[7:4] == ST_NOTE_ON && m_tdata[23:22] == LEN_THREE)

endmodule

bind midi_event_encoder_held_notes mee_checker u_mee_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);
